// ===== design/rmst_pkg.sv =====
package rmst_pkg;

  // Tree geometry
  localparam int MAX_POSITIONS = 1024;
  localparam int LEAF_W        = $clog2(MAX_POSITIONS);
  localparam int NODE_W        = LEAF_W + 1;        // node index, entries 0 .. 2*MAX-1
  localparam int WALK_W        = NODE_W + 1;        // query bounds during the walk
  localparam int TREE_DEPTH    = 2 * MAX_POSITIONS;

  // Field widths
  localparam int POS_W   = 10;
  localparam int VAL_W   = 32;
  localparam int RANGE_W = 11;
  localparam int CNT_W   = 11;

  // Configuration port
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-3:0] REG_POSITIONS_IN_USE = '0;

  typedef logic signed [VAL_W-1:0] value_t;

  localparam value_t INT_MAX = 32'sh7FFF_FFFF;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_t;

  // One write and two reads per cycle into the tree memory
  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    value_t            wdata;
    logic [NODE_W-1:0] raddr_a;
    logic [NODE_W-1:0] raddr_b;
  } mem_req_t;

  function automatic value_t smin(value_t a, value_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

// ===== design/rmst_tree_mem.sv =====
module rmst_tree_mem
  import rmst_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output value_t   rd_a,
  output value_t   rd_b
);

  value_t tree_mem [TREE_DEPTH];
  value_t rd_a_r;
  value_t rd_b_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      tree_mem[req.waddr] <= req.wdata;
    end
    rd_a_r <= tree_mem[req.raddr_a];
    rd_b_r <= tree_mem[req.raddr_b];
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

// ===== design/rmst_cfg.sv =====
module rmst_cfg
  import rmst_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output logic [CNT_W-1:0]  positions_in_use
);

  logic [CNT_W-1:0] piu_r;
  logic [CNT_W-1:0] piu_nxt;
  logic [CNT_W-1:0] wr_val;
  logic             wr_en;

  assign wr_en  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                  (cfg_paddr[CFG_AW-1:2] == REG_POSITIONS_IN_USE);
  assign wr_val = cfg_pwdata[CNT_W-1:0];

  // saturate into 1 .. MAX_POSITIONS
  always_comb begin
    piu_nxt = piu_r;
    if (wr_en) begin
      priority if (wr_val == '0) begin
        piu_nxt = CNT_W'(1);
      end else if (wr_val > CNT_W'(MAX_POSITIONS)) begin
        piu_nxt = CNT_W'(MAX_POSITIONS);
      end else begin
        piu_nxt = wr_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      piu_r <= CNT_W'(MAX_POSITIONS);
    end else begin
      piu_r <= piu_nxt;
    end
  end

  assign cfg_pready       = 1'b1;
  assign cfg_prdata       = CFG_DW'(piu_r);
  assign positions_in_use = piu_r;

endmodule

// ===== design/rmst_seq.sv =====
module rmst_seq
  import rmst_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CNT_W-1:0]   positions_in_use,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  cmd_t               in_cmd,
  input  logic [POS_W-1:0]   in_position,
  input  value_t             in_new_value,
  input  logic [RANGE_W-1:0] in_range_start,
  input  logic [RANGE_W-1:0] in_range_end,
  output logic               out_tvalid,
  input  logic               out_tready,
  output value_t             out_range_minimum,
  output mem_req_t           mem_req,
  input  value_t             rd_a,
  input  value_t             rd_b
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_UPD   = 5'b00100,
    S_QRY   = 5'b01000,
    S_QEND  = 5'b10000
  } state_t;

  state_t            state_r,    state_nxt;
  logic [NODE_W-1:0] clr_r,      clr_nxt;
  logic              s1_act_r,   s1_act_nxt;
  logic              s2_act_r,   s2_act_nxt;
  logic              out_vld_r,  out_vld_nxt;

  // payload
  logic [NODE_W-1:0] k_r,        k_nxt;
  value_t            cur_r,      cur_nxt;
  logic [WALK_W-1:0] lo_r,       lo_nxt;
  logic [WALK_W-1:0] hi_r,       hi_nxt;
  logic              s1_va_r,    s1_va_nxt;
  logic              s1_vb_r,    s1_vb_nxt;
  value_t            pair_r,     pair_nxt;
  value_t            res_r,      res_nxt;
  value_t            out_data_r, out_data_nxt;

  logic              accept;
  logic [NODE_W-1:0] leaf;
  logic [NODE_W-1:0] parent;
  logic [RANGE_W-1:0] end_clip;
  logic [WALK_W-1:0] hi_dec;
  value_t            up_min;
  logic              out_free;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign leaf      = NODE_W'(MAX_POSITIONS) + NODE_W'(in_position);
  assign parent    = k_r >> 1;
  assign up_min    = smin(cur_r, rd_a);
  assign end_clip  = (in_range_end > RANGE_W'(positions_in_use)) ?
                     RANGE_W'(positions_in_use) : in_range_end;
  assign hi_dec    = hi_r - WALK_W'(hi_r[0]);
  assign out_free  = !out_vld_r || out_tready;

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    k_nxt        = k_r;
    cur_nxt      = cur_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    s1_act_nxt   = 1'b0;
    s1_va_nxt    = s1_va_r;
    s1_vb_nxt    = s1_vb_r;
    s2_act_nxt   = s1_act_r;
    pair_nxt     = pair_r;
    res_nxt      = res_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_data_nxt = out_data_r;
    mem_req      = '0;

    // query datapath: masked pair minimum, then fold into the running minimum
    if (s1_act_r) begin
      pair_nxt = smin(s1_va_r ? rd_a : INT_MAX, s1_vb_r ? rd_b : INT_MAX);
    end
    if (s2_act_r) begin
      res_nxt = smin(res_r, pair_r);
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_r;
        mem_req.wdata = '0;
        clr_nxt       = clr_r + NODE_W'(1);
        if (clr_r == NODE_W'(TREE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_UPDATE) begin
            if (CNT_W'(in_position) < positions_in_use) begin
              // leaf write and sibling read in the transfer cycle
              mem_req.we      = 1'b1;
              mem_req.waddr   = leaf;
              mem_req.wdata   = in_new_value;
              mem_req.raddr_a = leaf ^ NODE_W'(1);
              k_nxt           = leaf;
              cur_nxt         = in_new_value;
              state_nxt       = S_UPD;
            end
          end else begin
            lo_nxt    = WALK_W'(in_range_start) + WALK_W'(MAX_POSITIONS);
            hi_nxt    = WALK_W'(end_clip) + WALK_W'(MAX_POSITIONS);
            res_nxt   = INT_MAX;
            state_nxt = S_QRY;
          end
        end
      end
      S_UPD: begin
        mem_req.we      = 1'b1;
        mem_req.waddr   = parent;
        mem_req.wdata   = up_min;
        mem_req.raddr_a = parent ^ NODE_W'(1);
        cur_nxt         = up_min;
        k_nxt           = parent;
        if (parent == NODE_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_QRY: begin
        if (lo_r < hi_r) begin
          mem_req.raddr_a = lo_r[NODE_W-1:0];
          mem_req.raddr_b = hi_dec[NODE_W-1:0];
          s1_act_nxt      = 1'b1;
          s1_va_nxt       = lo_r[0];
          s1_vb_nxt       = hi_r[0];
          lo_nxt          = (lo_r + WALK_W'(lo_r[0])) >> 1;
          hi_nxt          = hi_dec >> 1;
        end else begin
          state_nxt = S_QEND;
        end
      end
      S_QEND: begin
        if (!s1_act_r && !s2_act_r && out_free) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = res_r;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      s1_act_r  <= 1'b0;
      s2_act_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      s1_act_r  <= s1_act_nxt;
      s2_act_r  <= s2_act_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    cur_r      <= cur_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    s1_va_r    <= s1_va_nxt;
    s1_vb_r    <= s1_vb_nxt;
    pair_r     <= pair_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid        = out_vld_r;
  assign out_range_minimum = out_data_r;

  // the climb never reads the node it writes in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> (mem_req.waddr != mem_req.raddr_a))
    else $error("tree read and write hit the same node");

  // the climb stays below the root
  a_climb_above_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> (k_r > NODE_W'(1)))
    else $error("update climbed past the root");

  // only a finished query raises a result
  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r == S_QEND))
    else $error("result raised outside query end");

  // no result is loaded while the read pipeline still holds data
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QEND && state_nxt == S_IDLE) |-> (!s1_act_r && !s2_act_r))
    else $error("query result taken before pipeline drained");

endmodule

// ===== design/range_minimum_segment_tree_unit.sv =====
// Range-minimum segment tree over MAX_POSITIONS (1024) signed 32-bit values,
// kept in one 2048-entry tree memory (leaf i at entry 1024+i, node k combines
// entries 2k and 2k+1), with one write port and two read ports whose read data
// is registered. After reset the block runs a clearing pass, one entry per cycle,
// with in_tready low; the configuration port works during it.
// positions_in_use (register 0, reset 1024, writes saturate to 1..1024)
// sets how many leading positions are in use. An update (tuser = 0) writes
// the leaf in its transfer cycle and then climbs one level per cycle over
// the 10 levels, reading the sibling and writing the parent. An update at or
// beyond positions_in_use is dropped. A query (tuser = 1) returns the
// minimum over [range_start, min(range_end, positions_in_use)), or
// 2147483647 when that range is empty; it walks both bounds upward one level
// per cycle using both read ports, then drains a two-stage compare pipeline
// into the output register. One item is in work at a time; the result waits
// there, so the next item can be transferred while it is held.
module range_minimum_segment_tree_unit
  import rmst_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [63:0]       in_tdata,   // position[9:0], new_value[41:10],
                                        // range_start[52:42], range_end[63:53]
  input  logic              in_tuser,   // cmd[0]: 0 update, 1 query
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,  // range_minimum[31:0]
  // configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [CNT_W-1:0] positions_in_use;
  mem_req_t         mem_req;
  value_t           rd_a;
  value_t           rd_b;
  value_t           range_minimum;
  cmd_t             cmd;

  // unpack the transfer payload
  assign cmd = cmd_t'(in_tuser);

  rmst_cfg u_cfg (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready),
    .positions_in_use (positions_in_use)
  );

  rmst_tree_mem u_mem (
    .clk  (clk),
    .req  (mem_req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  rmst_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .positions_in_use  (positions_in_use),
    .in_tvalid         (in_tvalid),
    .in_tready         (in_tready),
    .in_cmd            (cmd),
    .in_position       (in_tdata[9:0]),
    .in_new_value      (value_t'(in_tdata[41:10])),
    .in_range_start    (in_tdata[52:42]),
    .in_range_end      (in_tdata[63:53]),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_range_minimum (range_minimum),
    .mem_req           (mem_req),
    .rd_a              (rd_a),
    .rd_b              (rd_b)
  );

  assign out_tdata = range_minimum;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

// Checks the range-minimum segment tree unit against a behavioral copy of the
// array it keeps. Point updates land in a local leaf array, and queries are
// answered by a linear scan over the clipped range. Results are compared in
// order as they leave the block.
module testbench;
  import rmst_pkg::*;

  // One input item, split into its fields before packing onto the bus.
  typedef struct {
    cmd_t                cmd;
    logic [POS_W-1:0]    position;
    value_t              new_value;
    logic [RANGE_W-1:0]  range_start;
    logic [RANGE_W-1:0]  range_end;
  } tree_op_t;

  localparam value_t INT_MIN = 32'sh8000_0000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [63:0]       in_tdata = '0;     // position[9:0], new_value[41:10],
                                        // range_start[52:42], range_end[63:53]
  logic              in_tuser = 1'b0;   // cmd[0]
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [31:0]       out_tdata;         // range_minimum[31:0]
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // Mirror of the block: leaf values and the used-position count.
  value_t      leaf_values [MAX_POSITIONS];
  int unsigned used_positions;
  value_t      pending_minimums [$];   // one per accepted query, oldest first

  int fail_count;

  // Sender pacing: burst length left, and the longest gap between bursts
  // (zero means valid never drops between items).
  int burst_left;
  int tx_gap_max;
  // Receiver pacing: longest stall between ready runs, plus a one-shot
  // hold-off request in cycles.
  int rx_stall_max;
  int holdoff_request;

  range_minimum_segment_tree_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop. The slowest legal run needs under a fifth of this.
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Mirror model
  // ---------------------------------------------------------------------------

  // Register write semantics: 11 bits kept, then saturated to 1..MAX.
  function automatic int unsigned saturate_positions(logic [31:0] word);
    int unsigned v;
    v = 32'(word[10:0]);
    if (v < 1) v = 1;
    if (v > MAX_POSITIONS) v = MAX_POSITIONS;
    return v;
  endfunction

  // Minimum over [lo, min(hi, used)); empty range gives INT_MAX.
  function automatic value_t range_minimum_of(int unsigned lo, int unsigned hi);
    value_t m;
    m = INT_MAX;
    if (hi > used_positions) hi = used_positions;
    for (int unsigned i = lo; i < hi; i++)
      if (leaf_values[i] < m) m = leaf_values[i];
    return m;
  endfunction

  // Apply one accepted item to the mirror.
  task automatic apply_op(input tree_op_t op);
    if (op.cmd == CMD_UPDATE) begin
      // out-of-range updates are dropped silently
      if (32'(op.position) < used_positions) leaf_values[op.position] = op.new_value;
    end else begin
      pending_minimums = {pending_minimums,
                          range_minimum_of(32'(op.range_start), 32'(op.range_end))};
    end
  endtask

  // Item builders; the fields an operation ignores get random junk.
  function automatic tree_op_t update_op(int unsigned pos, value_t val);
    tree_op_t op;
    op.cmd         = CMD_UPDATE;
    op.position    = pos[POS_W-1:0];
    op.new_value   = val;
    op.range_start = RANGE_W'($urandom);
    op.range_end   = RANGE_W'($urandom);
    return op;
  endfunction

  function automatic tree_op_t query_op(int unsigned lo, int unsigned hi);
    tree_op_t op;
    op.cmd         = CMD_QUERY;
    op.position    = POS_W'($urandom);
    op.new_value   = $urandom;
    op.range_start = lo[RANGE_W-1:0];
    op.range_end   = hi[RANGE_W-1:0];
    return op;
  endfunction

  // ---------------------------------------------------------------------------
  // Bus tasks (all called at a rising edge, return at a rising edge)
  // ---------------------------------------------------------------------------

  // Offer one item, wait for the transfer, then maybe start a gap.
  // Valid is left high within a burst so back-to-back items never toggle it.
  task automatic send_op(input tree_op_t op);
    in_tvalid <= 1'b1;
    in_tuser  <= op.cmd;
    in_tdata  <= {op.range_end, op.range_start, op.new_value, op.position};
    do @(posedge clk); while (!in_tready);
    apply_op(op);
    if (tx_gap_max != 0) begin
      if (burst_left == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, tx_gap_max)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Stop sending, wait until every query came back, then let a trailing
  // update finish its climb before touching the register.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_minimums.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  // Write positions_in_use, then read it back; the read must show the
  // saturated value.
  task automatic write_positions(input logic [31:0] word);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_POSITIONS_IN_USE, 2'b00};
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    used_positions = saturate_positions(word);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== CFG_DW'(used_positions)) begin
      $error("positions_in_use: expected %0d, actual %0d", used_positions, cfg_prdata);
      fail_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Receiver: ready runs of random length split by stalls up to rx_stall_max,
  // and a long hold-off when one is requested.
  initial begin : result_receiver
    int ready_left;
    int stall_left;
    int hold_left;
    ready_left = 0;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (holdoff_request > 0) begin
        hold_left       = holdoff_request;
        holdoff_request = 0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (ready_left > 0) begin
          ready_left--;
        end else begin
          ready_left = $urandom_range(1, 20);
          stall_left = (rx_stall_max == 0) ? 0 : $urandom_range(0, rx_stall_max);
        end
      end
    end
  end

  // Each result transfer is matched against the oldest pending query.
  always @(posedge clk) begin : result_check
    value_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_minimums.size() == 0) begin
        $error("range_minimum: expected none, actual %0d", $signed(out_tdata));
        fail_count++;
      end else begin
        want = pending_minimums.pop_front();
        if (out_tdata !== want) begin
          $error("range_minimum: expected %0d, actual %0d", want, $signed(out_tdata));
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Freshly cleared tree: everything reads zero; empty ranges give INT_MAX.
  task automatic test_cleared_tree();
    send_op(query_op(0, MAX_POSITIONS));
    send_op(query_op(7, 7));
    send_op(query_op(MAX_POSITIONS, MAX_POSITIONS));
    send_op(query_op(10, 3));
    send_op(query_op(MAX_POSITIONS - 1, MAX_POSITIONS));
  endtask

  // Value extremes at the edge positions, and a walk that needs both bounds.
  task automatic test_update_extremes();
    send_op(update_op(0, INT_MIN));
    send_op(update_op(MAX_POSITIONS - 1, INT_MAX));
    send_op(query_op(0, MAX_POSITIONS));
    send_op(query_op(1, MAX_POSITIONS));
    send_op(query_op(MAX_POSITIONS - 1, MAX_POSITIONS));
    send_op(update_op(513, -1));
    send_op(update_op(682, 32'sh5555_5555));
    send_op(query_op(1, 1023));
    send_op(query_op(514, 1023));
    send_op(query_op(0, 1));
  endtask

  // Register saturation, dropped updates and clipped query ends.
  task automatic test_positions_in_use();
    wait_idle();
    write_positions(5);
    send_op(update_op(5, -99));          // beyond the used range: dropped
    send_op(update_op(4, -7));
    send_op(query_op(0, MAX_POSITIONS)); // end clipped to 5
    send_op(query_op(1, MAX_POSITIONS));
    send_op(query_op(5, MAX_POSITIONS)); // nothing left after clipping
    wait_idle();
    write_positions(0);                  // saturates to 1
    send_op(query_op(0, MAX_POSITIONS));
    wait_idle();
    write_positions(2047);               // saturates to MAX
    send_op(query_op(5, 6));             // the dropped update left zero here
    wait_idle();
    write_positions(2048);               // low 11 bits are zero: saturates to 1
    wait_idle();
    write_positions(32'hFFFF_FFFF);
    wait_idle();
    write_positions(MAX_POSITIONS);
  endtask

  // Values hidden by a smaller register come back unchanged when it grows.
  task automatic test_register_change();
    send_op(update_op(900, -12345));
    wait_idle();
    write_positions(3);
    send_op(update_op(900, 777));        // dropped
    send_op(query_op(0, 1000));
    wait_idle();
    write_positions(MAX_POSITIONS);
    send_op(query_op(900, 901));
  endtask

  // Receiver stops for a long stretch while items keep coming, so the output
  // register fills and the input side has to stall.
  task automatic test_output_holdoff();
    wait_idle();
    tx_gap_max      = 0;
    holdoff_request = 300;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 0) send_op(update_op($urandom_range(0, 63), $urandom_range(0, 400) - 200));
      else            send_op(query_op($urandom_range(0, 31), $urandom_range(16, 64)));
    end
  endtask

  // One random item under the current register setting. Mostly in-range
  // updates with moderate values so the minima keep moving.
  function automatic tree_op_t random_op();
    int unsigned r;
    int unsigned pos;
    int unsigned a;
    int unsigned b;
    value_t      val;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      pos = ($urandom_range(0, 9) < 8) ? $urandom_range(0, used_positions - 1)
                                       : $urandom_range(0, MAX_POSITIONS - 1);
      case ($urandom_range(0, 9))
        0:       val = ($urandom_range(0, 1) != 0) ? INT_MIN : INT_MAX;
        1:       val = ($urandom_range(0, 1) != 0) ? 32'sd0 : -32'sd1;
        2, 3, 4: val = $urandom;
        default: val = $urandom_range(0, 2000) - 1000;
      endcase
      return update_op(pos, val);
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      a = $urandom_range(0, used_positions);
      b = $urandom_range(0, used_positions);
      if (a > b) begin
        pos = a; a = b; b = pos;
      end
      if ($urandom_range(0, 6) == 0) b = MAX_POSITIONS;
      return query_op(a, b);
    end else if (r < 85) begin
      return query_op($urandom_range(0, MAX_POSITIONS), $urandom_range(0, MAX_POSITIONS));
    end else begin
      pos = $urandom_range(0, used_positions - 1);
      return query_op(pos, pos + 1);
    end
  endfunction

  task automatic random_phase(input int unsigned positions, input int n_items,
                              input int gap_max, input int stall_max);
    wait_idle();
    write_positions(positions);
    tx_gap_max   = gap_max;
    rx_stall_max = stall_max;
    burst_left   = 0;
    for (int i = 0; i < n_items; i++) send_op(random_op());
  endtask

  // Several register settings, the extremes among them, each with its own
  // pacing; the first phase runs with no idling on either side.
  task automatic test_random_traffic();
    random_phase(MAX_POSITIONS, 400, 0, 0);
    random_phase(1,             150, 4, 3);
    random_phase(2,             150, 2, 6);
    random_phase(37,            250, 6, 2);
    random_phase(1000,          300, 3, 4);
    random_phase(MAX_POSITIONS, 450, 8, 8);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    for (int i = 0; i < MAX_POSITIONS; i++) leaf_values[i] = '0;
    used_positions  = MAX_POSITIONS;
    fail_count      = 0;
    burst_left      = 0;
    tx_gap_max      = 3;
    rx_stall_max    = 4;
    holdoff_request = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The block clears its tree memory first; input transfers simply wait.
    test_cleared_tree();
    test_update_extremes();
    test_positions_in_use();
    test_register_change();
    test_output_holdoff();
    test_random_traffic();

    wait_idle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
